FILE: rtl/bglex_pkg.sv
package bglex_pkg;

    // scanner mode between characters
    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_SYMBOL   = 2'd1,
        MODE_TERMINAL = 2'd2,
        MODE_WORD     = 2'd3
    } t_mode;

    // token kind reported with each character
    typedef enum logic [3:0] {
        KIND_SEP      = 4'd0,
        KIND_SYMBOL   = 4'd1,
        KIND_TERMINAL = 4'd2,
        KIND_WORD     = 4'd3,
        KIND_LBRACE   = 4'd4,
        KIND_RBRACE   = 4'd5,
        KIND_LBRACKET = 4'd6,
        KIND_RBRACKET = 4'd7,
        KIND_PIPE     = 4'd8,
        KIND_END      = 4'd9
    } t_kind;

    localparam int unsigned CH_W = 8;

    // character codes
    localparam logic [CH_W-1:0] CH_LT     = 8'h3C;
    localparam logic [CH_W-1:0] CH_GT     = 8'h3E;
    localparam logic [CH_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CH_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CH_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CH_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CH_W-1:0] CH_PIPE   = 8'h7C;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CH_W-1:0] CH_VT     = 8'h0B;
    localparam logic [CH_W-1:0] CH_FF     = 8'h0C;
    localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;

    // one tagged character
    typedef struct packed {
        logic [CH_W-1:0] ch_out;
        t_kind           kind;
        logic            starts_token;
        logic            closes_token;
        logic            word_ended_before;
        logic            unterminated;
    } t_result;

    // punctuator kind, separator code when not a punctuator
    function automatic t_kind punct_kind(input logic [CH_W-1:0] c);
        t_kind k;
        k = KIND_SEP;
        case (c)
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_LBRACK: k = KIND_LBRACKET;
            CH_RBRACK: k = KIND_RBRACKET;
            CH_PIPE:   k = KIND_PIPE;
            default:   k = KIND_SEP;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/bglex_scan.sv
module bglex_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic [bglex_pkg::CH_W-1:0]   i_ch,
    input  logic                         i_eot,
    output bglex_pkg::t_result           o_res
);

    bglex_pkg::t_mode r_mode, n_mode;
    logic             r_dq, n_dq;

    logic             is_white;
    logic             is_punct;
    logic             word_ends;
    bglex_pkg::t_kind pk;
    bglex_pkg::t_mode eff_mode;
    logic [bglex_pkg::CH_W-1:0] close_q;

    // character classes
    always_comb begin
        is_white = i_ch inside {bglex_pkg::CH_SPACE, bglex_pkg::CH_TAB, bglex_pkg::CH_LF,
                                bglex_pkg::CH_VT, bglex_pkg::CH_FF, bglex_pkg::CH_CR};
        pk       = bglex_pkg::punct_kind(i_ch);
        is_punct = (pk != bglex_pkg::KIND_SEP);
        close_q  = r_dq ? bglex_pkg::CH_DQUOTE : bglex_pkg::CH_SQUOTE;
        word_ends = (r_mode == bglex_pkg::MODE_WORD) && (is_white || is_punct);
        eff_mode  = word_ends ? bglex_pkg::MODE_IDLE : r_mode;
    end

    // next mode
    always_comb begin
        n_mode = r_mode;
        n_dq   = r_dq;
        if (i_eot) begin
            n_mode = bglex_pkg::MODE_IDLE;
            n_dq   = 1'b0;
        end else begin
            case (eff_mode)
                bglex_pkg::MODE_SYMBOL: begin
                    if (i_ch == bglex_pkg::CH_GT) n_mode = bglex_pkg::MODE_IDLE;
                end
                bglex_pkg::MODE_TERMINAL: begin
                    if (i_ch == close_q) n_mode = bglex_pkg::MODE_IDLE;
                end
                bglex_pkg::MODE_WORD: begin
                    n_mode = bglex_pkg::MODE_WORD;
                end
                bglex_pkg::MODE_IDLE: begin
                    if (is_white || is_punct) begin
                        n_mode = bglex_pkg::MODE_IDLE;
                    end else if (i_ch == bglex_pkg::CH_LT) begin
                        n_mode = bglex_pkg::MODE_SYMBOL;
                    end else if (i_ch == bglex_pkg::CH_SQUOTE ||
                                 i_ch == bglex_pkg::CH_DQUOTE) begin
                        n_mode = bglex_pkg::MODE_TERMINAL;
                        n_dq   = (i_ch == bglex_pkg::CH_DQUOTE);
                    end else begin
                        n_mode = bglex_pkg::MODE_WORD;
                    end
                end
                default: n_mode = bglex_pkg::MODE_IDLE;
            endcase
        end
    end

    // result fields
    always_comb begin
        o_res                   = '0;
        o_res.ch_out            = i_ch;
        o_res.kind              = bglex_pkg::KIND_SEP;
        if (i_eot) begin
            o_res.ch_out            = '0;
            o_res.kind              = bglex_pkg::KIND_END;
            o_res.word_ended_before = (r_mode == bglex_pkg::MODE_WORD);
            o_res.unterminated      = (r_mode == bglex_pkg::MODE_SYMBOL) ||
                                      (r_mode == bglex_pkg::MODE_TERMINAL);
        end else begin
            o_res.word_ended_before = word_ends;
            case (eff_mode)
                bglex_pkg::MODE_SYMBOL: begin
                    o_res.kind         = bglex_pkg::KIND_SYMBOL;
                    o_res.closes_token = (i_ch == bglex_pkg::CH_GT);
                end
                bglex_pkg::MODE_TERMINAL: begin
                    o_res.kind         = bglex_pkg::KIND_TERMINAL;
                    o_res.closes_token = (i_ch == close_q);
                end
                bglex_pkg::MODE_WORD: begin
                    o_res.kind = bglex_pkg::KIND_WORD;
                end
                bglex_pkg::MODE_IDLE: begin
                    if (is_white) begin
                        o_res.kind = bglex_pkg::KIND_SEP;
                    end else if (i_ch == bglex_pkg::CH_LT) begin
                        o_res.kind         = bglex_pkg::KIND_SYMBOL;
                        o_res.starts_token = 1'b1;
                    end else if (i_ch == bglex_pkg::CH_SQUOTE ||
                                 i_ch == bglex_pkg::CH_DQUOTE) begin
                        o_res.kind         = bglex_pkg::KIND_TERMINAL;
                        o_res.starts_token = 1'b1;
                    end else if (is_punct) begin
                        o_res.kind         = pk;
                        o_res.starts_token = 1'b1;
                        o_res.closes_token = 1'b1;
                    end else begin
                        o_res.kind         = bglex_pkg::KIND_WORD;
                        o_res.starts_token = 1'b1;
                    end
                end
                default: o_res.kind = bglex_pkg::KIND_SEP;
            endcase
        end
    end

    // mode register, moves once per processed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bglex_pkg::MODE_IDLE;
            r_dq   <= 1'b0;
        end else if (i_adv) begin
            r_mode <= n_mode;
            r_dq   <= n_dq;
        end
    end

    // end marker always leaves the scanner between tokens
    a_eot_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_eot) |=> (r_mode == bglex_pkg::MODE_IDLE && !r_dq))
        else $error("mode not cleared after end marker");

    // a started word keeps the scanner in word mode
    a_word_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res.starts_token && o_res.kind == bglex_pkg::KIND_WORD)
        |=> (r_mode == bglex_pkg::MODE_WORD))
        else $error("word start did not enter word mode");

    // a word can only end when one was in progress
    a_word_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.word_ended_before |-> (r_mode == bglex_pkg::MODE_WORD))
        else $error("word end flagged outside a word");

endmodule

FILE: rtl/bglex_out_reg.sv
module bglex_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  bglex_pkg::t_result  i_res,
    input  logic                i_stall,
    output logic                o_valid,
    output bglex_pkg::t_result  o_res
);

    logic               r_valid;
    bglex_pkg::t_result r_res;

    // result holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    // a new result is only loaded into a free or draining slot
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_valid || !i_stall))
        else $error("result overwritten while stalled");

    // unterminated flag only on the end result
    a_unterm_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.unterminated) |-> (r_res.kind == bglex_pkg::KIND_END))
        else $error("unterminated flag on a character result");

    // end result carries no character and opens no token
    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.kind == bglex_pkg::KIND_END)
        |-> (r_res.ch_out == '0 && !r_res.starts_token && !r_res.closes_token))
        else $error("malformed end result");

endmodule

FILE: rtl/bnf_grammar_char_lexer.sv
// BNF grammar character lexer
// Input channel: i_in_valid / o_in_stall carry one character (i_ch) or an
// end-of-text marker (i_end_of_text); a transaction completes on a rising
// edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carry one tagged result per
// input transaction, in order: echoed character, token kind, token start
// and close flags, word-ended flag and, on the END result, the
// unterminated flag.
// Path: the input transaction loads the input register; from there the
// scanner logic moves it into the result register when that slot frees up.
// Throughput: one transaction per cycle while i_out_stall is low; the
// scanner mode register is updated in the same cycle a character moves
// into the result register.
// Stall: while the result register is held by i_out_stall, one more
// character waits in the input register; o_in_stall rises only when both
// are full.
// Reset: i_rst_n is synchronous, active low; it empties both registers and
// returns the scanner to the between-tokens mode.
module bnf_grammar_char_lexer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [bglex_pkg::CH_W-1:0] i_ch,
    input  logic                       i_end_of_text,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [bglex_pkg::CH_W-1:0] o_ch_out,
    output logic [3:0]                 o_kind,
    output logic                       o_starts_token,
    output logic                       o_closes_token,
    output logic                       o_word_ended_before,
    output logic                       o_unterminated
);

    logic                       r_in_valid;
    logic [bglex_pkg::CH_W-1:0] r_ch;
    logic                       r_eot;
    logic                       adv;
    logic                       out_valid;
    bglex_pkg::t_result         scan_res;
    bglex_pkg::t_result         out_res;

    // move the held character on when the result slot frees up
    assign adv        = r_in_valid && (!out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_ch  <= i_ch;
            r_eot <= i_end_of_text;
        end
    end

    // scanner
    bglex_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ch    (r_ch),
        .i_eot   (r_eot),
        .o_res   (scan_res)
    );

    // result register
    bglex_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_res   (scan_res),
        .i_stall (i_out_stall),
        .o_valid (out_valid),
        .o_res   (out_res)
    );

    // output ports
    assign o_out_valid         = out_valid;
    assign o_ch_out            = out_res.ch_out;
    assign o_kind              = out_res.kind;
    assign o_starts_token      = out_res.starts_token;
    assign o_closes_token      = out_res.closes_token;
    assign o_word_ended_before = out_res.word_ended_before;
    assign o_unterminated      = out_res.unterminated;

endmodule
